FILE: design/gdw_pkg.sv
// Shared types and constants for the Gregorian date and weekday pipeline.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gdw_pkg;

   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int DAYS_W      = 22;
   localparam int DAYS_FULL_W = 23;
   localparam int WDAY_W      = 3;
   localparam int CENT_W      = 8;
   localparam int LEAPS_W     = 12;
   localparam int MSTART_W    = 9;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 1;

   localparam int YEAR_LIMIT_DEFAULT = 9999;

   localparam logic [YEAR_W-1:0]  BASE_YEAR         = 14'd1900;
   localparam logic [LEAPS_W-1:0] LEAPS_BEFORE_BASE = 12'd460;
   localparam int DAYS_PER_YEAR = 365;
   localparam int CENT_DIV      = 100;

   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
   localparam int DIV100_W     = 13;
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic                   ok;
      logic                   leap_adj;
      logic [DAYS_FULL_W-1:0] days_years;
      logic [LEAPS_W-1:0]     leaps;
      logic [MSTART_W-1:0]    mstart;
      logic [DAY_W-1:0]       day_off;
   } cal_type;

   typedef struct packed {
      logic                   ok;
      logic [DAYS_FULL_W-1:0] days;
   } sum_type;

endpackage

FILE: design/gdw_calendar.sv
// First two pipeline stages: century quotient, whole-year days, leap rule,
// range checks and month tables. Depends on gdw_pkg.
`timescale 1ns / 1ps

module gdw_calendar import gdw_pkg::*; #(
   parameter int YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  date_type in_date,
   output logic     out_valid,
   input  logic     out_ready,
   output cal_type  out_cal
);

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [MSTART_W-1:0] start;
      unique case (m)
         4'd1:    start = 9'd0;
         4'd2:    start = 9'd31;
         4'd3:    start = 9'd59;
         4'd4:    start = 9'd90;
         4'd5:    start = 9'd120;
         4'd6:    start = 9'd151;
         4'd7:    start = 9'd181;
         4'd8:    start = 9'd212;
         4'd9:    start = 9'd243;
         4'd10:   start = 9'd273;
         4'd11:   start = 9'd304;
         4'd12:   start = 9'd334;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

   // Stage 1 registers.
   logic                          s1_valid_ff;
   date_type                      s1_date_ff;
   logic [CENT_W-1:0]             s1_cent_ff, s1_cent_in;
   logic [DAYS_FULL_W-1:0]        s1_years_ff, s1_years_in;
   logic                          s1_ready;
   logic [YEAR_W+DIV100_W-1:0]    prod100;
   logic [YEAR_W-1:0]             year_off;

   // Stage 2 registers.
   logic                          s2_valid_ff;
   cal_type                       s2_cal_ff, s2_cal_in;
   logic                          s2_ready;

   // Stage 2 logic.
   logic [YEAR_W-1:0]             cent_hund;
   logic [YEAR_W-1:0]             rem100;
   logic                          cent_edge;
   logic                          leap;
   logic [YEAR_W-1:0]             year_prev;
   logic [CENT_W-1:0]             cent_prev;
   logic                          year_ok, month_ok, day_ok;
   logic [DAY_W-1:0]              mlen;

   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = s1_ready;

   assign prod100     = (YEAR_W+DIV100_W)'(in_date.year) * (YEAR_W+DIV100_W)'(DIV100_MUL);
   assign s1_cent_in  = prod100[DIV100_SHIFT +: CENT_W];
   assign year_off    = in_date.year - BASE_YEAR;
   assign s1_years_in = DAYS_FULL_W'(year_off) * DAYS_FULL_W'(DAYS_PER_YEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready && in_valid) begin
         s1_date_ff  <= in_date;
         s1_cent_ff  <= s1_cent_in;
         s1_years_ff <= s1_years_in;
      end
   end

   always_comb begin
      cent_hund = YEAR_W'(s1_cent_ff) * YEAR_W'(CENT_DIV);
      rem100    = s1_date_ff.year - cent_hund;
      cent_edge = (rem100 == '0);
      // A century year is a leap year only when its century count is a multiple of four.
      leap      = (s1_date_ff.year[1:0] == 2'b00) &&
                  (!cent_edge || (s1_cent_ff[1:0] == 2'b00));
      year_prev = s1_date_ff.year - YEAR_W'(1);
      cent_prev = s1_cent_ff - CENT_W'(cent_edge);

      year_ok  = (s1_date_ff.year >= BASE_YEAR) && (int'(s1_date_ff.year) <= YEAR_LIMIT);
      month_ok = (s1_date_ff.month >= MONTH_JAN) && (s1_date_ff.month <= MONTH_DEC);
      mlen     = month_len(s1_date_ff.month, leap);
      day_ok   = (s1_date_ff.day != '0) && (s1_date_ff.day <= mlen);

      s2_cal_in = '0;
      if (year_ok && month_ok && day_ok) begin
         s2_cal_in.ok         = 1'b1;
         s2_cal_in.leap_adj   = leap && (s1_date_ff.month > MONTH_FEB);
         s2_cal_in.days_years = s1_years_ff;
         s2_cal_in.leaps      = LEAPS_W'(year_prev >> 2) - LEAPS_W'(cent_prev)
                              + LEAPS_W'(cent_prev >> 2) - LEAPS_BEFORE_BASE;
         s2_cal_in.mstart     = month_start(s1_date_ff.month);
         s2_cal_in.day_off    = s1_date_ff.day - DAY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_cal_ff <= s2_cal_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_cal   = s2_cal_ff;

endmodule

FILE: design/gdw_day_sum.sv
// Third pipeline stage: adds the parts of the day count since the base date.
// Depends on gdw_pkg.
`timescale 1ns / 1ps

module gdw_day_sum import gdw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cal_type in_cal,
   output logic    out_valid,
   input  logic    out_ready,
   output sum_type out_sum
);

   logic    valid_ff;
   sum_type sum_ff, sum_in;

   assign in_ready = !valid_ff || out_ready;

   // Invalid dates arrive with every part zero, so the sum is zero too.
   always_comb begin
      sum_in.ok   = in_cal.ok;
      sum_in.days = in_cal.days_years
                  + DAYS_FULL_W'(in_cal.leaps)
                  + DAYS_FULL_W'(in_cal.mstart)
                  + DAYS_FULL_W'(in_cal.leap_adj)
                  + DAYS_FULL_W'(in_cal.day_off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;

endmodule

FILE: design/gdw_weekday.sv
// Last pipeline stage and output register: day count modulo seven and the
// result fields. Depends on gdw_pkg.
`timescale 1ns / 1ps

module gdw_weekday import gdw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sum_type           in_sum,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_date_valid,
   output logic [DAYS_W-1:0] out_days,
   output logic [WDAY_W-1:0] out_weekday
);

   localparam int DIGITS = (DAYS_FULL_W + 2) / 3;
   localparam int DSUM_W = $clog2(DIGITS * 7 + 1);

   logic                    valid_ff;
   logic                    date_valid_ff;
   logic [DAYS_W-1:0]       days_ff;
   logic [WDAY_W-1:0]       weekday_ff, weekday_in;
   logic [DIGITS*3-1:0]     padded;
   logic [DSUM_W-1:0]       dsum;
   logic [3:0]              fold_a;
   logic [2:0]              fold_b;

   assign in_ready = !valid_ff || out_ready;

   // Since 8 == 1 mod 7, the octal digit sum keeps the residue; two folds
   // bring it to 0..7, and 7 stands for 0.
   always_comb begin
      padded = (DIGITS*3)'(in_sum.days);
      dsum   = '0;
      for (int i = 0; i < DIGITS; i++) begin
         dsum = dsum + DSUM_W'(padded[3*i +: 3]);
      end
      fold_a     = 4'(dsum[DSUM_W-1:3]) + 4'(dsum[2:0]);
      fold_b     = 3'(fold_a[3]) + fold_a[2:0];
      weekday_in = (fold_b == 3'd7) ? '0 : fold_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         date_valid_ff <= in_sum.ok;
         days_ff       <= in_sum.days[DAYS_W-1:0];
         weekday_ff    <= weekday_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_date_valid = date_valid_ff;
   assign out_days       = days_ff;
   assign out_weekday    = weekday_ff;

endmodule

FILE: design/gregorian_date_weekday.sv
// Top level of the Gregorian date check and weekday pipeline.
// Depends on gdw_pkg, gdw_calendar, gdw_day_sum and gdw_weekday.
//
//   Channel  Direction  Item contents
//   req_     in         day_of_month, month_number, year_number
//   rsp_     out        date_valid, days_since_base, weekday
//
// One item enters per cycle unless every stage is full behind a stalled result;
// each result passes through the four register stages (century quotient, leap
// rule and checks, day sum, modulo seven), the first of which loads at the
// accepting edge. Reset clears only the stage valid bits; no memory needs
// clearing. Each stage holds its item while the next one is full, so bubbles
// close up and a stalled result never blocks empty stages.
`timescale 1ns / 1ps

module gregorian_date_weekday import gdw_pkg::*; #(
   parameter int YEAR_LIMIT = YEAR_LIMIT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] day_of_month, [8:5] month_number, [22:9] year_number, [23] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [21:0] days_since_base, [24:22] weekday, [31:25] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] date_valid
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   date_type          req_date;
   logic              cal_valid, cal_ready;
   cal_type           cal;
   logic              sum_valid, sum_ready;
   sum_type           sum;
   logic              date_valid;
   logic [DAYS_W-1:0] days;
   logic [WDAY_W-1:0] weekday;

   assign req_date = date_type'(req_tdata[$bits(date_type)-1:0]);

   gdw_calendar #(
      .YEAR_LIMIT (YEAR_LIMIT)
   ) u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_date   (req_date),
      .out_valid (cal_valid),
      .out_ready (cal_ready),
      .out_cal   (cal)
   );

   gdw_day_sum u_day_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_valid),
      .in_ready  (cal_ready),
      .in_cal    (cal),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum)
   );

   gdw_weekday u_weekday (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (sum_valid),
      .in_ready       (sum_ready),
      .in_sum         (sum),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_date_valid (date_valid),
      .out_days       (days),
      .out_weekday    (weekday)
   );

   assign rsp_tdata = {(RSP_DATA_W-DAYS_W-WDAY_W)'(0), weekday, days};
   assign rsp_tuser = RSP_USER_W'(date_valid);

endmodule

FILE: design/gdw_checker.sv
// Port-level checks for the date and weekday pipeline, bound to the top level.
// Depends on gdw_pkg and gregorian_date_weekday.
`timescale 1ns / 1ps

module gdw_checker import gdw_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // A held result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // An empty output stage means every stage ahead of it can take an item.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A rejected date carries an all-zero result.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid date with nonzero result");

   // The weekday code stays in range and the padding stays clear.
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DAYS_W +: WDAY_W] != 3'd7) &&
                     (rsp_tdata[RSP_DATA_W-1:DAYS_W+WDAY_W] == '0))
      else $error("weekday out of range");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind gregorian_date_weekday gdw_checker u_checker (.*);
